// ----- rtl/core/sheared_box_deformation_update_core_macros.svh -----
// Assertion macros shared by the sheared box update checker.
`ifndef SHEARED_BOX_DEFORMATION_UPDATE_CORE_MACROS_SVH
`define SHEARED_BOX_DEFORMATION_UPDATE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SBDU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SBDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sbdu_pkg.sv -----
// Shared types, constants and saturation helper for the sheared box update.
`default_nettype none

package sbdu_pkg;

    localparam int MAX_SHIFTS_DEF = 8;
    localparam int NUM_LANES      = 6;
    localparam int WORD_W         = 32;
    localparam int STEP_W         = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int TIME_W         = 81;

    // Element slots of the lower-triangular box
    localparam int E_XX = 0;
    localparam int E_YX = 1;
    localparam int E_YY = 2;
    localparam int E_ZX = 3;
    localparam int E_ZY = 4;
    localparam int E_ZZ = 5;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

    // Growth magnitude ceiling, 2^33 in Q16.16
    localparam logic [33:0] GROW_CLAMP = 34'h2_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_XX_YX = 3'd0,
        REG_RATE_YY_ZX = 3'd1,
        REG_RATE_ZY_ZZ = 3'd2,
        REG_REF_XX_YX  = 3'd3,
        REG_REF_YY_ZX  = 3'd4,
        REG_REF_ZY_ZZ  = 3'd5,
        REG_TIME_STEP  = 3'd6,
        REG_FIRST_STEP = 3'd7
    } t_reg_idx;

    typedef logic [NUM_LANES-1:0][WORD_W-1:0] t_box;

    typedef struct packed {
        logic              done;
        logic              neg;
        logic [TIME_W-1:0] mag;
    } t_time_res;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_lane_stat;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_fix_res;

    typedef struct packed {
        logic              ovf;
        logic [WORD_W-1:0] val;
    } t_sat;

    // Sign-extend a box word to the 36-bit working width
    function automatic logic signed [35:0] sx36(input logic [WORD_W-1:0] a);
        return $signed({{4{a[WORD_W-1]}}, a});
    endfunction

    // Clamp a 36-bit signed value to 32 bits and report the clamp
    function automatic t_sat sat32(input logic signed [35:0] v);
        t_sat r;
        r.ovf = !((&v[35:31]) || !(|v[35:31]));
        if (r.ovf) begin
            r.val = v[35] ? WORD_MIN : WORD_MAX;
        end else begin
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sheared_box_deformation_update_core.sv -----
// Flow: the input beat is registered and passes the time unit, the lanes and the
// correction stage (row shifts, one shift a cycle) before the output register loads.
// Throughput: one item at a time; the next beat is taken in the cycle after the result
// is loaded, even while that result still waits at the output register.
// Reset: synchronous, active low; idles control, zeroes all configuration registers.
`default_nettype none

module sheared_box_deformation_update_core #(
    parameter int MAX_SHIFTS = sbdu_pkg::MAX_SHIFTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [sbdu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [sbdu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [sbdu_pkg::STEP_W-1:0]       i_step_number,
    input  wire logic signed [31:0]                i_in_xx,
    input  wire logic signed [31:0]                i_in_yx,
    input  wire logic signed [31:0]                i_in_yy,
    input  wire logic signed [31:0]                i_in_zx,
    input  wire logic signed [31:0]                i_in_zy,
    input  wire logic signed [31:0]                i_in_zz,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [31:0]                     o_out_xx,
    output logic signed [31:0]                     o_out_yx,
    output logic signed [31:0]                     o_out_yy,
    output logic signed [31:0]                     o_out_zx,
    output logic signed [31:0]                     o_out_zy,
    output logic signed [31:0]                     o_out_zz,
    output logic                                   o_shift_overflow
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TIME = 4'b0010,
        S_LANE = 4'b0100,
        S_FIX  = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [sbdu_pkg::CFG_DATA_W-1:0] r_rate [3];
    logic [sbdu_pkg::CFG_DATA_W-1:0] r_ref  [3];
    logic [sbdu_pkg::WORD_W-1:0] r_dt;
    logic [sbdu_pkg::STEP_W-1:0] r_first;
    logic [sbdu_pkg::STEP_W-1:0] r_step;
    sbdu_pkg::t_box              r_orig;
    logic                        r_kick;
    logic                        w_acc;
    logic                        w_load;
    sbdu_pkg::t_time_res         w_time;
    sbdu_pkg::t_lane_stat        w_lstat [sbdu_pkg::NUM_LANES];
    sbdu_pkg::t_box              w_lbox;
    logic                        w_lanes_done;
    logic                        w_lanes_ovf;
    sbdu_pkg::t_fix_res          w_fix;
    sbdu_pkg::t_box              w_fbox;
    logic                        r_out_vld;
    sbdu_pkg::t_box              r_out_box;
    logic                        r_out_ovf;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;
    assign w_load  = (r_state == S_FIX) && w_fix.done && (!r_out_vld || i_ready);

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= '{default: '0};
            r_ref   <= '{default: '0};
            r_dt    <= '0;
            r_first <= '0;
        end else if (i_cfg_we) begin
            unique case (sbdu_pkg::t_reg_idx'(i_cfg_idx))
                sbdu_pkg::REG_RATE_XX_YX: r_rate[0] <= i_cfg_data;
                sbdu_pkg::REG_RATE_YY_ZX: r_rate[1] <= i_cfg_data;
                sbdu_pkg::REG_RATE_ZY_ZZ: r_rate[2] <= i_cfg_data;
                sbdu_pkg::REG_REF_XX_YX:  r_ref[0]  <= i_cfg_data;
                sbdu_pkg::REG_REF_YY_ZX:  r_ref[1]  <= i_cfg_data;
                sbdu_pkg::REG_REF_ZY_ZZ:  r_ref[2]  <= i_cfg_data;
                sbdu_pkg::REG_TIME_STEP:  r_dt      <= i_cfg_data[31:0];
                sbdu_pkg::REG_FIRST_STEP: r_first   <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_step                   <= i_step_number;
            r_orig[sbdu_pkg::E_XX]   <= i_in_xx;
            r_orig[sbdu_pkg::E_YX]   <= i_in_yx;
            r_orig[sbdu_pkg::E_YY]   <= i_in_yy;
            r_orig[sbdu_pkg::E_ZX]   <= i_in_zx;
            r_orig[sbdu_pkg::E_ZY]   <= i_in_zy;
            r_orig[sbdu_pkg::E_ZZ]   <= i_in_zz;
        end
    end

    // Item sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_acc)        n_state = S_TIME;
            S_TIME:  if (w_time.done)  n_state = S_LANE;
            S_LANE:  if (w_lanes_done) n_state = S_FIX;
            S_FIX:   if (w_load)       n_state = S_IDLE;
            default:                   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kick  <= w_acc;
        end
    end

    sbdu_time u_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_step  (r_step),
        .i_first (r_first),
        .i_dt    (r_dt),
        .o_res   (w_time)
    );

    // One lane per box element; even lanes take the high half of their register
    for (genvar gl = 0; gl < sbdu_pkg::NUM_LANES; gl++) begin : g_lane
        sbdu_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_time.done),
            .i_mag   (w_time.mag),
            .i_neg   (w_time.neg),
            .i_rate  (r_rate[gl / 2][32 * (1 - (gl % 2)) +: 32]),
            .i_ref   (r_ref[gl / 2][32 * (1 - (gl % 2)) +: 32]),
            .i_orig  (r_orig[gl]),
            .o_stat  (w_lstat[gl]),
            .o_val   (w_lbox[gl])
        );
    end

    // Combine lane status
    always_comb begin
        w_lanes_done = 1'b1;
        w_lanes_ovf  = 1'b0;
        for (int k = 0; k < sbdu_pkg::NUM_LANES; k++) begin
            w_lanes_done = w_lanes_done & w_lstat[k].done;
            w_lanes_ovf  = w_lanes_ovf | w_lstat[k].ovf;
        end
    end

    sbdu_fix #(
        .MAX_SHIFTS (MAX_SHIFTS)
    ) u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lanes_done),
        .i_box   (w_lbox),
        .i_orig  (r_orig),
        .i_ovf   (w_lanes_ovf),
        .o_res   (w_fix),
        .o_box   (w_fbox)
    );

    // Output register: load a finished item, drop the beat once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_box <= w_fbox;
            r_out_ovf <= w_fix.ovf;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_out_xx         = r_out_box[sbdu_pkg::E_XX];
    assign o_out_yx         = r_out_box[sbdu_pkg::E_YX];
    assign o_out_yy         = r_out_box[sbdu_pkg::E_YY];
    assign o_out_zx         = r_out_box[sbdu_pkg::E_ZX];
    assign o_out_zy         = r_out_box[sbdu_pkg::E_ZY];
    assign o_out_zz         = r_out_box[sbdu_pkg::E_ZZ];
    assign o_shift_overflow = r_out_ovf;

endmodule

`default_nettype wire

// ----- rtl/core/sbdu_time.sv -----
// Elapsed-time unit: signed step count and its magnitude times the time step.
`default_nettype none

module sbdu_time (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sbdu_pkg::STEP_W-1:0]   i_step,
    input  wire logic [sbdu_pkg::STEP_W-1:0]   i_first,
    input  wire logic [sbdu_pkg::WORD_W-1:0]   i_dt,
    output sbdu_pkg::t_time_res                o_res
);

    logic [3:0]        r_vld;
    logic [49:0]       r_n;
    logic              r_neg;
    logic [48:0]       r_abs;
    logic [63:0]       r_p0;
    logic [48:0]       r_p1;
    logic [sbdu_pkg::TIME_W-1:0] r_mag;

    // Advance the stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    // Step count, magnitude, two partial products, then the merge
    always_ff @(posedge i_clk) begin
        r_n   <= {2'b00, i_step} + 50'd1 - {2'b00, i_first};
        r_neg <= r_n[49];
        r_abs <= r_n[49] ? 49'(-r_n) : r_n[48:0];
        r_p0  <= r_abs[31:0] * i_dt;
        r_p1  <= r_abs[48:32] * i_dt;
        r_mag <= {17'b0, r_p0} + {r_p1, 32'b0};
    end

    assign o_res.done = r_vld[3];
    assign o_res.neg  = r_neg;
    assign o_res.mag  = r_mag;

endmodule

`default_nettype wire

// ----- rtl/core/sbdu_lane.sv -----
// One box element lane: rate times elapsed time, rounding, clamp and reference add.
`default_nettype none

module sbdu_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sbdu_pkg::TIME_W-1:0]   i_mag,
    input  wire logic                          i_neg,
    input  wire logic [sbdu_pkg::WORD_W-1:0]   i_rate,
    input  wire logic [sbdu_pkg::WORD_W-1:0]   i_ref,
    input  wire logic [sbdu_pkg::WORD_W-1:0]   i_orig,
    output sbdu_pkg::t_lane_stat               o_stat,
    output logic [sbdu_pkg::WORD_W-1:0]        o_val
);

    // Lane step numbers
    localparam logic [2:0] LS_ACC0 = 3'd1;
    localparam logic [2:0] LS_ACC1 = 3'd2;
    localparam logic [2:0] LS_ACC2 = 3'd3;
    localparam logic [2:0] LS_MAG  = 3'd4;
    localparam logic [2:0] LS_SIGN = 3'd5;
    localparam logic [2:0] LS_LAST = 3'd6;

    logic               r_act;
    logic [2:0]         r_cnt;
    logic               r_done;
    logic               r_neg;
    logic               r_zero;
    logic [31:0]        r_mr;
    logic [31:0]        w_chunk;
    logic [63:0]        r_pp;
    logic [32:0]        r_carry;
    logic [64:0]        w_sum;
    logic [31:0]        r_w1;
    logic [48:0]        r_hi;
    logic [33:0]        r_gmag;
    logic signed [34:0] r_grow;
    logic signed [35:0] w_tot;
    sbdu_pkg::t_sat     w_sat;
    logic [31:0]        r_val;
    logic               r_ovf;

    // Sequence the lane steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_act && (r_cnt == LS_LAST);
            if (i_start) begin
                r_act <= 1'b1;
                r_cnt <= '0;
            end else if (r_act) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == LS_LAST) begin
                    r_act <= 1'b0;
                end
            end
        end
    end

    // Pick the 32-bit slice of the time product for this step
    always_comb begin
        case (r_cnt)
            3'd0:    w_chunk = i_mag[31:0];
            3'd1:    w_chunk = i_mag[63:32];
            default: w_chunk = {15'b0, i_mag[80:64]};
        endcase
    end

    assign w_sum = {32'b0, r_carry} + {1'b0, r_pp};
    assign w_tot = sbdu_pkg::sx36(i_ref) + 36'(r_grow);
    assign w_sat = sbdu_pkg::sat32(w_tot);

    // Multiply, accumulate, round and add the reference
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg   <= i_neg ^ i_rate[31];
            r_mr    <= i_rate[31] ? -i_rate : i_rate;
            r_zero  <= (i_rate == '0);
            r_carry <= '0;
        end else if (r_act) begin
            if (r_cnt <= LS_ACC1) begin
                r_pp <= w_chunk * r_mr;
            end
            if (r_cnt >= LS_ACC0 && r_cnt <= LS_ACC2) begin
                r_carry <= w_sum[64:32];
            end
            if (r_cnt == LS_ACC1) begin
                r_w1 <= w_sum[31:0];
            end
            if (r_cnt == LS_ACC2) begin
                r_hi <= w_sum[48:0];
            end
            if (r_cnt == LS_MAG) begin
                // Round half away from zero at bit 40, clamp to 2^33
                r_gmag <= (|r_hi[48:9]) ? sbdu_pkg::GROW_CLAMP
                        : {1'b0, r_hi[8:0], r_w1[31:8]} + 34'(r_w1[7]);
            end
            if (r_cnt == LS_SIGN) begin
                r_grow <= r_neg ? -$signed({1'b0, r_gmag}) : $signed({1'b0, r_gmag});
            end
            if (r_cnt == LS_LAST) begin
                r_val <= r_zero ? i_orig : w_sat.val;
                r_ovf <= !r_zero && w_sat.ovf;
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;
    assign o_val       = r_val;

endmodule

`default_nettype wire

// ----- rtl/core/sbdu_fix.sv -----
// Merge stage: off-diagonal drift correction by row shifts, one shift per cycle.
`default_nettype none

module sbdu_fix #(
    parameter int MAX_SHIFTS = sbdu_pkg::MAX_SHIFTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire sbdu_pkg::t_box i_box,
    input  wire sbdu_pkg::t_box i_orig,
    input  wire logic           i_ovf,
    output sbdu_pkg::t_fix_res  o_res,
    output sbdu_pkg::t_box      o_box
);

    localparam int CW = $clog2(MAX_SHIFTS + 1);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_YX   = 4'b0010,
        F_ZY   = 4'b0100,
        F_ZX   = 4'b1000
    } t_fix_state;

    t_fix_state         r_st, n_st;
    logic               r_add, n_add;
    logic [CW-1:0]      r_cnt, n_cnt;
    sbdu_pkg::t_box     r_box, n_box;
    logic               r_ovf, n_ovf;

    logic [31:0]        w_a;
    logic [31:0]        w_b;
    logic [31:0]        w_o;
    logic [32:0]        w_d;
    logic signed [33:0] w_d2;
    logic signed [33:0] w_g;
    logic               w_sub;
    logic               w_addt;
    logic               w_test;
    sbdu_pkg::t_sat     w_main;
    sbdu_pkg::t_sat     w_side;

    // Select the entry under test and the diagonal of its source row
    always_comb begin
        unique case (r_st)
            F_ZY: begin
                w_a = r_box[sbdu_pkg::E_ZY];
                w_b = r_box[sbdu_pkg::E_YY];
                w_o = i_orig[sbdu_pkg::E_ZY];
            end
            F_ZX: begin
                w_a = r_box[sbdu_pkg::E_ZX];
                w_b = r_box[sbdu_pkg::E_XX];
                w_o = i_orig[sbdu_pkg::E_ZX];
            end
            default: begin
                w_a = r_box[sbdu_pkg::E_YX];
                w_b = r_box[sbdu_pkg::E_XX];
                w_o = i_orig[sbdu_pkg::E_YX];
            end
        endcase
    end

    // Drift test: 2*D against the diagonal, exactly
    assign w_d    = {w_a[31], w_a} - {w_o[31], w_o};
    assign w_d2   = $signed({w_d, 1'b0});
    assign w_g    = $signed({{2{w_b[31]}}, w_b});
    assign w_sub  = w_d2 > w_g;
    assign w_addt = w_d2 < -w_g;
    assign w_test = r_add ? w_addt : w_sub;

    // Row shift candidates: entry against diagonal, and zx against yx for the zy step
    assign w_main = r_add ? sbdu_pkg::sat32(sbdu_pkg::sx36(w_a) + sbdu_pkg::sx36(w_b))
                          : sbdu_pkg::sat32(sbdu_pkg::sx36(w_a) - sbdu_pkg::sx36(w_b));
    assign w_side = r_add
        ? sbdu_pkg::sat32(sbdu_pkg::sx36(r_box[sbdu_pkg::E_ZX])
                          + sbdu_pkg::sx36(r_box[sbdu_pkg::E_YX]))
        : sbdu_pkg::sat32(sbdu_pkg::sx36(r_box[sbdu_pkg::E_ZX])
                          - sbdu_pkg::sx36(r_box[sbdu_pkg::E_YX]));

    // Next state of the correction sequencer
    always_comb begin
        n_st  = r_st;
        n_add = r_add;
        n_cnt = r_cnt;
        n_box = r_box;
        n_ovf = r_ovf;
        if (i_start) begin
            n_st  = F_YX;
            n_add = 1'b0;
            n_cnt = '0;
            n_box = i_box;
            n_ovf = i_ovf;
        end else if (r_st != F_IDLE) begin
            if (w_test && (r_cnt != CW'(MAX_SHIFTS))) begin
                // Apply one row shift
                n_cnt = r_cnt + CW'(1);
                n_ovf = r_ovf | w_main.ovf;
                unique case (r_st)
                    F_YX: n_box[sbdu_pkg::E_YX] = w_main.val;
                    F_ZY: begin
                        n_box[sbdu_pkg::E_ZY] = w_main.val;
                        n_box[sbdu_pkg::E_ZX] = w_side.val;
                        n_ovf = r_ovf | w_main.ovf | w_side.ovf;
                    end
                    F_ZX: n_box[sbdu_pkg::E_ZX] = w_main.val;
                    default: n_box = r_box;
                endcase
            end else if (!w_test && !r_add) begin
                // Subtractions done, try additions
                n_add = 1'b1;
            end else begin
                // Entry finished, or shift limit reached with the test still true
                if (w_test) begin
                    n_ovf = 1'b1;
                end
                n_add = 1'b0;
                n_cnt = '0;
                unique case (r_st)
                    F_YX:    n_st = F_ZY;
                    F_ZY:    n_st = F_ZX;
                    default: n_st = F_IDLE;
                endcase
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= F_IDLE;
            r_add <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_add <= n_add;
            r_cnt <= n_cnt;
        end
    end

    // Hold the working box
    always_ff @(posedge i_clk) begin
        r_box <= n_box;
        r_ovf <= n_ovf;
    end

    assign o_res.done = (r_st == F_IDLE);
    assign o_res.ovf  = r_ovf;
    assign o_box      = r_box;

endmodule

`default_nettype wire

// ----- rtl/core/sbdu_checker.sv -----
// Port-level checker for the sheared box update core, with its bind.
`default_nettype none

`include "sheared_box_deformation_update_core_macros.svh"

module sbdu_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_cfg_we,
    input wire logic [sbdu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input wire logic [sbdu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input wire logic                              i_valid,
    input wire logic                              o_ready,
    input wire logic [sbdu_pkg::STEP_W-1:0]       i_step_number,
    input wire logic signed [31:0]                i_in_xx,
    input wire logic signed [31:0]                i_in_yx,
    input wire logic signed [31:0]                i_in_yy,
    input wire logic signed [31:0]                i_in_zx,
    input wire logic signed [31:0]                i_in_zy,
    input wire logic signed [31:0]                i_in_zz,
    input wire logic                              o_valid,
    input wire logic                              i_ready,
    input wire logic signed [31:0]                o_out_xx,
    input wire logic signed [31:0]                o_out_yx,
    input wire logic signed [31:0]                o_out_yy,
    input wire logic signed [31:0]                o_out_zx,
    input wire logic signed [31:0]                o_out_zy,
    input wire logic signed [31:0]                o_out_zz,
    input wire logic                              o_shift_overflow
);

    // Taking a beat closes the input until that item is finished
    `SBDU_ASSERT_NEXT(a_take_blocks, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "input still open after a beat")

    // No result can appear in the cycle after a beat is taken
    `SBDU_ASSERT_NEXT(a_no_fast_result, i_clk, i_rst_n, i_valid && o_ready, !$rose(o_valid), "result too early")

    // A new result reopens the input in the same cycle
    `SBDU_ASSERT_NOW(a_result_frees_input, i_clk, i_rst_n, $rose(o_valid), $rose(o_ready), "input not reopened with result")

    // A stalled result holds
    `SBDU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_xx) && $stable(o_out_yx) && $stable(o_out_yy) && $stable(o_out_zx) && $stable(o_out_zy) && $stable(o_out_zz) && $stable(o_shift_overflow), "stalled result changed")

endmodule

bind sheared_box_deformation_update_core sbdu_checker u_sbdu_checker (.*);

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the sheared box deformation update core.
`timescale 1ns / 1ps

module testbench;
    import sbdu_pkg::*;

    localparam int SHIFT_LIMIT  = MAX_SHIFTS_DEF;
    localparam int RAND_PHASES  = 21;
    localparam int PHASE_BOXES  = 88;
    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        t_box              ent;
    } t_box_beat;

    typedef struct packed {
        t_box ent;
        logic ovf;
    } t_box_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    t_reg_idx              cfg_idx = REG_RATE_XX_YX;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_box_beat in_beat = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    logic      out_valid;
    logic      out_ready = 1'b0;
    logic signed [31:0] out_xx, out_yx, out_yy, out_zx, out_zy, out_zz;
    logic      out_ovf;

    // Local copy of the register file, as the block sees it
    logic [63:0]       cfg_rate [3];
    logic [63:0]       cfg_base [3];
    logic [31:0]       cfg_dt;
    logic [STEP_W-1:0] cfg_first;

    t_box_beat   boxes_to_send [$];
    t_box_result boxes_due [$];

    int n_queued = 0;
    int n_results = 0;
    int n_fail = 0;
    int n_flagged = 0;
    int n_settings = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    bit calm = 1'b0;
    int gap_left = 0;
    int stall_left = 0;

    // Shear set-up of the current phase, used to shape the boxes
    t_box              sh_ref;
    logic [STEP_W-1:0] sh_start;

    t_box        got_box;
    t_box_result want;
    string       lane_name [NUM_LANES] = '{"xx", "yx", "yy", "zx", "zy", "zz"};

    sheared_box_deformation_update_core #(
        .MAX_SHIFTS(SHIFT_LIMIT)
    ) i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_step_number    (in_beat.step),
        .i_in_xx          (in_beat.ent[E_XX]),
        .i_in_yx          (in_beat.ent[E_YX]),
        .i_in_yy          (in_beat.ent[E_YY]),
        .i_in_zx          (in_beat.ent[E_ZX]),
        .i_in_zy          (in_beat.ent[E_ZY]),
        .i_in_zz          (in_beat.ent[E_ZZ]),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_out_xx         (out_xx),
        .o_out_yx         (out_yx),
        .o_out_yy         (out_yy),
        .o_out_zx         (out_zx),
        .o_out_zy         (out_zy),
        .o_out_zz         (out_zz),
        .o_shift_overflow (out_ovf)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Clamp to the 32-bit word and flag the clamp
    function automatic longint clamp_word(longint v, output bit hit);
        hit = 1'b0;
        if (v > 64'sd2147483647) begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Rounded Q16.16 growth n * dt * rate, magnitude held at 2^33
    function automatic longint growth_q16(longint n, logic [31:0] dt, longint rate);
        logic [127:0] prod;
        logic [63:0]  mn;
        logic [63:0]  mr;
        logic         neg;
        longint       mag;
        neg  = (n < 0) != (rate < 0);
        mn   = (n < 0) ? -n : n;
        mr   = (rate < 0) ? -rate : rate;
        prod = 128'(mn) * 128'(dt) * 128'(mr[31:0]);
        prod = (prod + (128'(1) << 39)) >> 40;
        if (prod > (128'(1) << 33)) prod = 128'(1) << 33;
        mag = longint'(prod[63:0]);
        return neg ? -mag : mag;
    endfunction

    // Expected box after the deformation step and the re-wrap of the tilts
    function automatic t_box_result update_box(t_box_beat b);
        t_box_result r;
        longint      orig [NUM_LANES];
        longint      e [NUM_LANES];
        longint      n, rate, base, drift2, dir;
        logic [31:0] rate_w, base_w;
        int          i, j, off, dg, cnt;
        bit          flag, hit, stop;
        flag = 1'b0;
        n = longint'({16'd0, b.step}) + 1 - longint'({16'd0, cfg_first});
        for (int k = 0; k < NUM_LANES; k++) begin
            rate_w  = k[0] ? cfg_rate[k / 2][31:0] : cfg_rate[k / 2][63:32];
            base_w  = k[0] ? cfg_base[k / 2][31:0] : cfg_base[k / 2][63:32];
            rate    = longint'($signed(rate_w));
            base    = longint'($signed(base_w));
            orig[k] = longint'($signed(b.ent[k]));
            e[k]    = orig[k];
            if (rate != 0) begin
                e[k] = clamp_word(base + growth_q16(n, cfg_dt, rate), hit);
                flag |= hit;
            end
        end
        // Re-wrap yx against x, zy against y, then zx against x
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin i = 1; j = 0; end
                1: begin i = 2; j = 1; end
                default: begin i = 2; j = 0; end
            endcase
            off  = i * (i + 1) / 2 + j;
            dg   = j * (j + 1) / 2 + j;
            cnt  = 0;
            dir  = 1;
            stop = 1'b0;
            while (!stop) begin
                drift2 = 2 * (e[off] - orig[off]);
                if (dir == 1 && !(drift2 > e[dg])) dir = -1;
                if (dir == -1 && !(drift2 < -e[dg])) begin
                    stop = 1'b1;
                end else if (cnt >= SHIFT_LIMIT) begin
                    flag = 1'b1;
                    stop = 1'b1;
                end else begin
                    for (int c = 0; c <= j; c++) begin
                        e[i * (i + 1) / 2 + c] = clamp_word(
                            e[i * (i + 1) / 2 + c] - dir * e[j * (j + 1) / 2 + c], hit);
                        flag |= hit;
                    end
                    cnt++;
                end
            end
        end
        for (int k = 0; k < NUM_LANES; k++) r.ent[k] = e[k][31:0];
        r.ovf = flag;
        return r;
    endfunction

    // Drive one beat at a time, with random bursts of idle cycles
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && in_ready) boxes_due.push_back(update_box(in_beat));
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (boxes_to_send.size() != 0) begin
                    if (!calm && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                        gap_left <= $urandom_range(5);
                        in_valid <= 1'b0;
                    end else begin
                        in_beat  <= boxes_to_send.pop_front();
                        in_valid <= 1'b1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        n_fail++;
        if (n_fail <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
    endtask

    // Take results with random stalls and check them in order
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && out_ready) begin
                n_results++;
                got_box[E_XX] = out_xx;
                got_box[E_YX] = out_yx;
                got_box[E_YY] = out_yy;
                got_box[E_ZX] = out_zx;
                got_box[E_ZY] = out_zy;
                got_box[E_ZZ] = out_zz;
                if (boxes_due.size() == 0) begin
                    n_fail++;
                    if (n_fail <= REPORT_LIMIT)
                        $display("%0t: result beat with no box pending, expected none, got %h",
                                 $time, got_box);
                end else begin
                    want = boxes_due.pop_front();
                    for (int k = 0; k < NUM_LANES; k++)
                        if (got_box[k] !== want.ent[k])
                            note_mismatch({"out_", lane_name[k]}, want.ent[k], got_box[k]);
                    if (out_ovf !== want.ovf)
                        note_mismatch("shift_overflow", 32'(want.ovf), 32'(out_ovf));
                    if (want.ovf) n_flagged++;
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end else if (!calm && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                stall_left <= $urandom_range(5);
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RATE_XX_YX: cfg_rate[0] = val;
            REG_RATE_YY_ZX: cfg_rate[1] = val;
            REG_RATE_ZY_ZZ: cfg_rate[2] = val;
            REG_REF_XX_YX:  cfg_base[0] = val;
            REG_REF_YY_ZX:  cfg_base[1] = val;
            REG_REF_ZY_ZZ:  cfg_base[2] = val;
            REG_TIME_STEP:  cfg_dt = val[31:0];
            REG_FIRST_STEP: cfg_first = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                                 logic [63:0] b0, logic [63:0] b1, logic [63:0] b2,
                                 logic [63:0] dt, logic [63:0] start);
        write_reg(REG_RATE_XX_YX, r0);
        write_reg(REG_RATE_YY_ZX, r1);
        write_reg(REG_RATE_ZY_ZZ, r2);
        write_reg(REG_REF_XX_YX, b0);
        write_reg(REG_REF_YY_ZX, b1);
        write_reg(REG_REF_ZY_ZZ, b2);
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_FIRST_STEP, start);
        n_settings++;
    endtask

    task automatic queue_box(logic [STEP_W-1:0] st, logic [31:0] xx, logic [31:0] yx,
                             logic [31:0] yy, logic [31:0] zx, logic [31:0] zy,
                             logic [31:0] zz);
        t_box_beat b;
        b.step        = st;
        b.ent[E_XX]   = xx;
        b.ent[E_YX]   = yx;
        b.ent[E_YY]   = yy;
        b.ent[E_ZX]   = zx;
        b.ent[E_ZY]   = zy;
        b.ent[E_ZZ]   = zz;
        boxes_to_send.push_back(b);
        n_queued++;
    endtask

    // Hold until every queued box has come back
    task automatic wait_drained();
        while (n_results < n_queued) @(posedge clk);
    endtask

    function automatic logic [31:0] jitter(int unsigned m);
        int v;
        v = int'($urandom_range(2 * m)) - int'(m);
        return v;
    endfunction

    function automatic logic [31:0] shear_rate();
        logic [31:0] mag;
        mag = $urandom_range(32'h1_0000, 1) << $urandom_range(10);
        if ($urandom_range(2) == 0) return '0;
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // Plausible box: positive diagonal, tilts within half a diagonal
    task automatic pick_shear_setup();
        t_box        rates;
        t_box        base;
        logic [31:0] dt;
        base[E_XX] = $urandom_range(32'h40_0000, 32'h4_0000);
        base[E_YY] = $urandom_range(32'h40_0000, 32'h4_0000);
        base[E_ZZ] = $urandom_range(32'h40_0000, 32'h4_0000);
        base[E_YX] = jitter(base[E_XX] / 2);
        base[E_ZX] = jitter(base[E_XX] / 2);
        base[E_ZY] = jitter(base[E_YY] / 2);
        for (int k = 0; k < NUM_LANES; k++) rates[k] = shear_rate();
        dt       = ($urandom | 32'h0001_0000) >> $urandom_range(14);
        sh_start = ({$urandom, $urandom} & 64'h00FF_FFFF_FFFF) | 64'h40;
        sh_ref   = base;
        apply_setting({rates[E_XX], rates[E_YX]}, {rates[E_YY], rates[E_ZX]},
                      {rates[E_ZY], rates[E_ZZ]}, {base[E_XX], base[E_YX]},
                      {base[E_YY], base[E_ZX]}, {base[E_ZY], base[E_ZZ]},
                      64'(dt), 64'(sh_start));
    endtask

    function automatic logic [63:0] wild_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(7) == 0) return '1;
        if ($urandom_range(2) == 0) w[63:32] = '0;
        if ($urandom_range(2) == 0) w[31:0] = '0;
        return w;
    endfunction

    task automatic pick_wild_setup();
        apply_setting(wild_word(), wild_word(), wild_word(), wild_word(), wild_word(),
                      wild_word(), wild_word(), wild_word());
    endtask

    task automatic queue_noise_box();
        t_box        b;
        logic [47:0] st;
        st = $urandom_range(1) ? 48'({$urandom, $urandom})
                               : cfg_first + $urandom_range(64) - 8;
        for (int k = 0; k < NUM_LANES; k++) begin
            b[k] = $urandom;
            if ($urandom_range(1)) b[k] = $signed(b[k]) >>> $urandom_range(30);
        end
        queue_box(st, b[E_XX], b[E_YX], b[E_YY], b[E_ZX], b[E_ZY], b[E_ZZ]);
    endtask

    // Box close to the reference, tilts offset by up to a diagonal
    task automatic queue_shear_box();
        t_box        b;
        logic [47:0] st;
        st = sh_start - 4 + $urandom_range(3000);
        b  = sh_ref;
        b[E_YX] = sh_ref[E_YX] + jitter(sh_ref[E_XX]);
        b[E_ZX] = sh_ref[E_ZX] + jitter(sh_ref[E_XX]);
        b[E_ZY] = sh_ref[E_ZY] + jitter(sh_ref[E_YY]);
        if ($urandom_range(3) == 0) b[E_XX] = sh_ref[E_XX] + jitter(sh_ref[E_XX] / 8);
        if ($urandom_range(3) == 0) b[E_YY] = sh_ref[E_YY] + jitter(sh_ref[E_YY] / 8);
        if ($urandom_range(3) == 0) b[E_ZZ] = sh_ref[E_ZZ] + jitter(sh_ref[E_ZZ] / 8);
        queue_box(st, b[E_XX], b[E_YX], b[E_YY], b[E_ZX], b[E_ZY], b[E_ZZ]);
    endtask

    initial begin
        cfg_rate  = '{default: '0};
        cfg_base  = '{default: '0};
        cfg_dt    = '0;
        cfg_first = '0;
        idle_pct  = 25;
        stall_pct = 25;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: zero rates, boxes pass through; negative diagonal hits the limit
        queue_box('0, '0, '0, '0, '0, '0, '0);
        queue_box(48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_box(48'd5, 32'hFFFF_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                  32'h8000_0000);
        queue_box(48'd7, 32'h0, 32'h1234_5678, 32'h0, 32'h8765_4321, 32'h7FFF_FFFF, 32'h0);
        wait_drained();

        // Shear of a 16-unit cube: before start, at start, one wrap, shift limit
        apply_setting({32'h0, 32'h0100_0000}, {32'h0, 32'hFF00_0000},
                      {32'h0080_0000, 32'h0}, {32'h0010_0000, 32'h0},
                      {32'h0010_0000, 32'h0}, {32'h0, 32'h0010_0000},
                      64'h8000_0000, 64'd1000);
        queue_box(48'd999, 32'h0010_0000, 32'h0, 32'h0010_0000, 32'h0, 32'h0, 32'h0010_0000);
        queue_box(48'd998, 32'h0010_0000, 32'h0, 32'h0010_0000, 32'h0, 32'h0, 32'h0010_0000);
        queue_box(48'd1000, 32'h0010_0000, 32'h0, 32'h0010_0000, 32'h0, 32'h0, 32'h0010_0000);
        queue_box(48'd1040, 32'h0010_0000, 32'h0, 32'h0010_0000, 32'h0, 32'h0, 32'h0010_0000);
        queue_box(48'd1040, 32'h0010_0000, 32'h0020_0000, 32'h0010_0000, 32'hFFE0_0000,
                  32'h0, 32'h0010_0000);
        queue_box(48'd1300, 32'h0010_0000, 32'h0, 32'h0010_0000, 32'h0, 32'h0, 32'h0010_0000);
        wait_drained();

        // Half-LSB growth rounds away from zero; huge step count clamps the growth
        apply_setting({32'h0100_0000, 32'hFF00_0000}, '0, '0, '0, '0, '0,
                      64'h0000_8000, 64'd0);
        queue_box(48'd0, '0, '0, '0, '0, '0, '0);
        queue_box(48'd2, '0, '0, '0, '0, '0, '0);
        queue_box(48'hFFFF_FFFF_FFFF, '0, '0, '0, '0, '0, '0);
        wait_drained();

        // Extreme rates and references, longest time step, latest start
        apply_setting(64'h8000_0000_7FFF_FFFF, 64'h8000_0000_7FFF_FFFF,
                      64'h8000_0000_7FFF_FFFF, 64'h7FFF_FFFF_8000_0000,
                      64'h7FFF_FFFF_8000_0000, 64'h7FFF_FFFF_8000_0000,
                      64'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF);
        queue_box(48'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0,
                  32'h7FFF_FFFF);
        queue_box(48'hFFFF_FFFF_FFFF, '0, '0, '0, '0, '0, '0);
        queue_box(48'hFFFF_FFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_drained();

        // Every register all ones, then back to all zeros
        apply_setting('1, '1, '1, '1, '1, '1, '1, '1);
        queue_box(48'hFFFF_FFFF_FFFF, 32'h0001_0000, '0, 32'h0001_0000, '0, '0, 32'h0001_0000);
        queue_box(48'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        wait_drained();
        apply_setting('0, '0, '0, '0, '0, '0, '0, '0);
        queue_box(48'h8000_0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                  32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
        wait_drained();

        // Random phases: mostly plausible shears, every fourth a wild setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            calm = (ph >= RAND_PHASES - 2);
            case (ph % 3)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 15; stall_pct = 25; end
                default: begin idle_pct = 45; stall_pct = 45; end
            endcase
            if (ph % 4 == 3) pick_wild_setup();
            else pick_shear_setup();
            for (int k = 0; k < PHASE_BOXES; k++) begin
                if (ph % 4 == 3 || $urandom_range(9) == 0) queue_noise_box();
                else queue_shear_box();
            end
            wait_drained();
        end

        repeat (64) @(posedge clk);
        if (boxes_due.size() != 0) begin
            n_fail++;
            $display("%0t: %0d boxes never came back", $time, boxes_due.size());
        end
        $display("tb summary: %0d boxes checked under %0d register settings, %0d with overflow",
                 n_results, n_settings, n_flagged);
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("%0t: watchdog expired with %0d of %0d boxes back", $time, n_results, n_queued);
        $display("tb: failure");
        $finish;
    end

endmodule
